[design/rbm_pkg.sv]
// Shared constants, codes and control bundles for the row buffer memory.
package rbm_pkg;

   // Geometry and address map
   localparam int ROW_WORDS          = 256;
   localparam int NUM_ROWS           = 512;
   localparam int DATA_SEGMENT_START = 1000;

   // Field widths
   localparam int ADDR_W   = 19;
   localparam int DATA_W   = 32;
   localparam int DELAY_W  = 10;
   localparam int LAT_W    = 12;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 2;
   localparam int BYTE_W   = 2;

   // Derived widths
   localparam int COL_W    = $clog2(ROW_WORDS);
   localparam int ROW_W    = $clog2(NUM_ROWS);
   localparam int STORE_AW = ROW_W + COL_W;
   localparam int SWEEP_W  = COL_W + 1;

   // Stream packing
   localparam int REQ_FIELDS_W = ADDR_W + DATA_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = DATA_W + LAT_W + 1 + COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SWEEP,
      ST_ACCESS,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_REJECT,
      MODE_FIRST,
      MODE_HIT,
      MODE_MISS
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_LOW      = 2'd1,
      STATUS_MISALIGN = 2'd2
   } status_type;

   typedef enum logic {
      CSR_ROW_DELAY    = 1'b0,
      CSR_COLUMN_DELAY = 1'b1
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;
      logic capture;
      logic decide;
      logic sweep;
      logic access;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic reject;
      logic row_hit;
      logic sweep_done;
      logic out_free;
   } stat_type;

endpackage

[design/rbm_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module rbm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/rbm_ctrl.sv]
// Sequencer: clear pass, request intake, row sweep, column access, result hand-off.
module rbm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  rbm_pkg::stat_type st,
   output rbm_pkg::cmd_type  cmd
);

   rbm_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rbm_pkg::ST_CLEAR: begin
            if (st.clear_done) state_in = rbm_pkg::ST_IDLE;
         end
         rbm_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = rbm_pkg::ST_CHECK;
         end
         rbm_pkg::ST_CHECK: begin
            if (st.reject) begin
               state_in = rbm_pkg::ST_DONE;
            end else if (st.row_hit) begin
               state_in = rbm_pkg::ST_ACCESS;
            end else begin
               state_in = rbm_pkg::ST_SWEEP;
            end
         end
         rbm_pkg::ST_SWEEP: begin
            if (st.sweep_done) state_in = rbm_pkg::ST_ACCESS;
         end
         rbm_pkg::ST_ACCESS: begin
            state_in = rbm_pkg::ST_DONE;
         end
         rbm_pkg::ST_DONE: begin
            if (st.out_free) state_in = rbm_pkg::ST_IDLE;
         end
         default: begin
            state_in = rbm_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         rbm_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         rbm_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         rbm_pkg::ST_CHECK: begin
            cmd.decide = 1'b1;
         end
         rbm_pkg::ST_SWEEP: begin
            cmd.sweep = 1'b1;
         end
         rbm_pkg::ST_ACCESS: begin
            cmd.access = 1'b1;
         end
         rbm_pkg::ST_DONE: begin
            cmd.emit = st.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[design/rbm_dp.sv]
// Datapath: delay registers, request latch, row buffer, backing store, result register.
module rbm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rbm_pkg::cmd_type              cmd,
   output rbm_pkg::stat_type             st,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [rbm_pkg::DELAY_W-1:0]   csr_wdata,
   input  logic                          req_kind,
   input  logic [rbm_pkg::ADDR_W-1:0]    req_address,
   input  logic [rbm_pkg::DATA_W-1:0]    req_write_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rbm_pkg::DATA_W-1:0]    rsp_read_data,
   output logic [rbm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rbm_pkg::LAT_W-1:0]     rsp_latency,
   output logic                          rsp_row_hit,
   output logic [rbm_pkg::COUNT_W-1:0]   rsp_row_loads
);

   localparam int DW  = rbm_pkg::DATA_W;
   localparam int LW  = rbm_pkg::LAT_W;
   localparam int CW  = rbm_pkg::COL_W;
   localparam int RW  = rbm_pkg::ROW_W;
   localparam int SW  = rbm_pkg::SWEEP_W;

   // Delay registers
   logic [rbm_pkg::DELAY_W-1:0] row_delay_ff, row_delay_in;
   logic [rbm_pkg::DELAY_W-1:0] col_delay_ff, col_delay_in;

   always_comb begin
      row_delay_in = row_delay_ff;
      col_delay_in = col_delay_ff;
      if (csr_we) begin
         unique case (rbm_pkg::csr_index_type'(csr_index))
            rbm_pkg::CSR_ROW_DELAY:    row_delay_in = csr_wdata;
            rbm_pkg::CSR_COLUMN_DELAY: col_delay_in = csr_wdata;
            default:                   row_delay_in = row_delay_ff;
         endcase
      end
   end

   // Request latch
   logic                             kind_ff, kind_in;
   logic [rbm_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [DW-1:0]                    wdata_ff, wdata_in;

   assign kind_in  = cmd.capture ? req_kind       : kind_ff;
   assign addr_in  = cmd.capture ? req_address    : addr_ff;
   assign wdata_in = cmd.capture ? req_write_data : wdata_ff;

   // Address decode
   logic [RW-1:0] row_sel;
   logic [CW-1:0] col_sel;
   logic          below_seg;
   logic          misaligned;

   assign row_sel    = addr_ff[rbm_pkg::BYTE_W + CW +: RW];
   assign col_sel    = addr_ff[rbm_pkg::BYTE_W +: CW];
   assign below_seg  = addr_ff < rbm_pkg::ADDR_W'(rbm_pkg::DATA_SEGMENT_START);
   assign misaligned = addr_ff[rbm_pkg::BYTE_W-1:0] != '0;

   // Open row tracking
   logic [RW-1:0]                 open_row_ff, open_row_in;
   logic                          any_open_ff, any_open_in;
   logic [rbm_pkg::COUNT_W-1:0]   loads_ff, loads_in;
   rbm_pkg::mode_type             mode_ff, mode_in;
   rbm_pkg::status_type           status_ff, status_in;

   logic row_hit;
   assign row_hit = any_open_ff && (open_row_ff == row_sel);

   always_comb begin
      mode_in   = mode_ff;
      status_in = status_ff;
      if (cmd.decide) begin
         if (below_seg) begin
            mode_in   = rbm_pkg::MODE_REJECT;
            status_in = rbm_pkg::STATUS_LOW;
         end else if (misaligned) begin
            mode_in   = rbm_pkg::MODE_REJECT;
            status_in = rbm_pkg::STATUS_MISALIGN;
         end else begin
            status_in = rbm_pkg::STATUS_OK;
            if (!any_open_ff) begin
               mode_in = rbm_pkg::MODE_FIRST;
            end else if (row_hit) begin
               mode_in = rbm_pkg::MODE_HIT;
            end else begin
               mode_in = rbm_pkg::MODE_MISS;
            end
         end
      end
   end

   // Sweep counter: one beat per word; a last beat drains the read pipeline
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] cnt_dec;
   logic [CW-1:0] widx;
   logic          sweep_done;
   logic          sweep_rd;
   logic          sweep_wr;
   logic          write_back;

   assign sweep_done = cnt_ff == SW'(rbm_pkg::ROW_WORDS);
   assign cnt_dec    = cnt_ff - 1'b1;
   assign widx       = cnt_dec[CW-1:0];
   assign sweep_rd   = cmd.sweep && !cnt_ff[CW];
   assign sweep_wr   = cmd.sweep && (cnt_ff != '0);
   assign write_back = mode_ff == rbm_pkg::MODE_MISS;

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.sweep) begin
         cnt_in = sweep_done ? '0 : cnt_ff + 1'b1;
      end
   end

   always_comb begin
      open_row_in = open_row_ff;
      any_open_in = any_open_ff;
      loads_in    = loads_ff;
      if (cmd.sweep && sweep_done) begin
         open_row_in = row_sel;
         any_open_in = 1'b1;
         if (loads_ff != '1) loads_in = loads_ff + 1'b1;
      end
   end

   // Clear pass over the row-written flags
   logic [RW-1:0] clr_ff, clr_in;
   assign clr_in = cmd.clear ? clr_ff + 1'b1 : clr_ff;

   // Memories
   logic          valid_rdata;
   logic [DW-1:0] store_rdata;
   logic [DW-1:0] buf_rdata;

   logic          buf_re, buf_we;
   logic [CW-1:0] buf_raddr, buf_waddr;
   logic [DW-1:0] buf_wdata;

   assign buf_re    = sweep_rd || (cmd.access && !kind_ff);
   assign buf_raddr = cmd.access ? col_sel : cnt_ff[CW-1:0];
   assign buf_we    = sweep_wr || (cmd.access && kind_ff);
   assign buf_waddr = cmd.access ? col_sel : widx;
   assign buf_wdata = cmd.access ? wdata_ff : (valid_rdata ? store_rdata : '0);

   rbm_ram #(
      .WIDTH (DW),
      .DEPTH (rbm_pkg::ROW_WORDS)
   ) u_row_buf (
      .clock (clock),
      .we    (buf_we),
      .waddr (buf_waddr),
      .wdata (buf_wdata),
      .re    (buf_re),
      .raddr (buf_raddr),
      .rdata (buf_rdata)
   );

   rbm_ram #(
      .WIDTH (DW),
      .DEPTH (rbm_pkg::NUM_ROWS * rbm_pkg::ROW_WORDS)
   ) u_store (
      .clock (clock),
      .we    (sweep_wr && write_back),
      .waddr ({open_row_ff, widx}),
      .wdata (buf_rdata),
      .re    (sweep_rd),
      .raddr ({row_sel, cnt_ff[CW-1:0]}),
      .rdata (store_rdata)
   );

   // One flag per row: set once the row has been written back
   rbm_ram #(
      .WIDTH (1),
      .DEPTH (rbm_pkg::NUM_ROWS)
   ) u_row_valid (
      .clock (clock),
      .we    (cmd.clear || (cmd.sweep && sweep_done && write_back)),
      .waddr (cmd.clear ? clr_ff : open_row_ff),
      .wdata (!cmd.clear),
      .re    (cmd.decide),
      .raddr (row_sel),
      .rdata (valid_rdata)
   );

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]         out_data_ff, out_data_in;
   logic [LW-1:0]         out_lat_ff, out_lat_in;
   logic                  out_hit_ff, out_hit_in;
   logic [rbm_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [rbm_pkg::COUNT_W-1:0]  out_loads_ff, out_loads_in;
   logic [LW-1:0]         base_lat;
   logic [LW-1:0]         row_lat;

   assign base_lat = LW'(col_delay_ff) + LW'(1);
   assign row_lat  = LW'(row_delay_ff);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_data_in   = out_data_ff;
      out_lat_in    = out_lat_ff;
      out_hit_in    = out_hit_ff;
      out_status_in = out_status_ff;
      out_loads_in  = out_loads_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         out_status_in = status_ff;
         out_loads_in  = loads_ff;
         out_data_in   = kind_ff ? wdata_ff : buf_rdata;
         out_hit_in    = 1'b0;
         case (mode_ff)
            rbm_pkg::MODE_FIRST: out_lat_in = base_lat + row_lat;
            rbm_pkg::MODE_HIT: begin
               out_lat_in = base_lat;
               out_hit_in = 1'b1;
            end
            rbm_pkg::MODE_MISS:  out_lat_in = base_lat + {row_lat[LW-2:0], 1'b0};
            default: begin
               out_lat_in  = '0;
               out_data_in = '0;
            end
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_delay_ff <= '0;
         col_delay_ff <= '0;
         open_row_ff  <= '0;
         any_open_ff  <= 1'b0;
         loads_ff     <= '0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_delay_ff <= row_delay_in;
         col_delay_ff <= col_delay_in;
         open_row_ff  <= open_row_in;
         any_open_ff  <= any_open_in;
         loads_ff     <= loads_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      wdata_ff      <= wdata_in;
      mode_ff       <= mode_in;
      status_ff     <= status_in;
      out_data_ff   <= out_data_in;
      out_lat_ff    <= out_lat_in;
      out_hit_ff    <= out_hit_in;
      out_status_ff <= out_status_in;
      out_loads_ff  <= out_loads_in;
   end

   // Status to the controller
   assign st.clear_done = clr_ff == RW'(rbm_pkg::NUM_ROWS - 1);
   assign st.reject     = below_seg || misaligned;
   assign st.row_hit    = row_hit;
   assign st.sweep_done = sweep_done;
   assign st.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_read_data = out_data_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_latency   = out_lat_ff;
   assign rsp_row_hit   = out_hit_ff;
   assign rsp_row_loads = out_loads_ff;

endmodule

[design/dram_row_buffer_memory_top.sv]
// Top level of the open-page row buffer memory: controller plus datapath.
//
//   channel  direction  beat contents
//   req_*    in         tuser: kind; tdata: address, write_data
//   rsp_*    out        tuser: status; tdata: read_data, latency, row_hit, row_loads
//   csr_*    in         csr_index selects row_delay (0) or column_delay (1)
//
// One item at a time. A reject goes straight to the hand-off, a row hit via a
// column access, a first access or row miss via a row sweep, then the access; the
// sweep moves one word per cycle, plus a drain beat, through the row buffer and
// backing store. After reset a pass clears the written flags of all 512 rows;
// req_tready stays low until it ends. A held result blocks only the next hand-off.
module dram_row_buffer_memory_top (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rbm_pkg::REQ_TDATA_W-1:0]   req_tdata,  // address, write_data
   input  logic                              req_tuser,  // kind
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rbm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // read_data, latency, row_hit, row_loads
   output logic [rbm_pkg::STATUS_W-1:0]      rsp_tuser,  // status
   // Configuration
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [rbm_pkg::DELAY_W-1:0]       csr_wdata
);

   rbm_pkg::cmd_type  cmd;
   rbm_pkg::stat_type st;

   logic [rbm_pkg::DATA_W-1:0]   rsp_read_data;
   logic [rbm_pkg::LAT_W-1:0]    rsp_latency;
   logic                         rsp_row_hit;
   logic [rbm_pkg::COUNT_W-1:0]  rsp_row_loads;

   rbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   rbm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_kind       (req_tuser),
      .req_address    (req_tdata[rbm_pkg::ADDR_W-1:0]),
      .req_write_data (req_tdata[rbm_pkg::ADDR_W +: rbm_pkg::DATA_W]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_tuser),
      .rsp_latency    (rsp_latency),
      .rsp_row_hit    (rsp_row_hit),
      .rsp_row_loads  (rsp_row_loads)
   );

   // Pack result fields, lowest first, zero pad to whole bytes
   assign rsp_tdata = {{(rbm_pkg::RSP_TDATA_W - rbm_pkg::RSP_FIELDS_W){1'b0}},
                       rsp_row_loads, rsp_row_hit, rsp_latency, rsp_read_data};

endmodule
